// ===== hw/rtl/assert_macros.svh =====
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at each clock edge outside reset
`define CHK_AT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("check failed");
// property checked during reset as well
`define CHK_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) else $error("check failed");
`endif

// ===== hw/rtl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants and types of the set-associative cache tag store.
// ----------------------------------------------------------------------------
package salc_pkg;
  localparam int MAX_SET_BITS_D = 6;
  localparam int MAX_WAYS_D = 8;
  localparam int ADDR_WIDTH_D = 64;
  localparam int MAX_BLOCK_BITS = 20;

  localparam logic [1:0] OUT_HIT = 2'd0;
  localparam logic [1:0] OUT_FILL = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch request, start row read
    logic decide;    // compare ways, register updated row and outcome
    logic finish;    // write row, present result
    logic clr_step;  // write one cleared row
    logic clr_start; // restart clearing sweep
  } salc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cfg_clr;   // write to a defined register, lines must be cleared
    logic clr_last;
  } salc_sts_t;
endpackage

// ===== hw/rtl/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/salc_ctrl.sv =====
// ----------------------------------------------------------------------------
// salc_ctrl
// Controller: clearing sweep and the three-step access sequence.
// ----------------------------------------------------------------------------
module salc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  salc_pkg::salc_sts_t sts,
  output salc_pkg::salc_cmd_t cmd,
  output logic                busy
);
  import salc_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.cfg_clr) begin
          cmd.clr_start = 1'b1;
        end else if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (sts.cfg_clr) begin
          cmd.clr_start = 1'b1;
          state_next = ST_CLEAR;
        end else if (start) begin
          cmd.capture = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.decide = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);
endmodule

// ===== hw/rtl/salc_dp.sv =====
// ----------------------------------------------------------------------------
// salc_dp
// Datapath: configuration, address split, set row RAM, way compare, LRU,
// statistics counters and result registers.
// ----------------------------------------------------------------------------
module salc_dp #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_D,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_D,
  parameter int ADDR_WIDTH = salc_pkg::ADDR_WIDTH_D
) (
  input  logic                  clk,
  input  logic                  rst,
  input  salc_pkg::salc_cmd_t   cmd,
  output salc_pkg::salc_sts_t   sts,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [4:0]            cfg_data,
  input  logic [ADDR_WIDTH-1:0] address,
  input  logic                  action,
  output logic                  done,
  output logic [1:0]            outcome,
  output logic [20:0]           written_back_bytes,
  output logic [31:0]           hit_count,
  output logic [31:0]           miss_count,
  output logic [31:0]           eviction_count,
  output logic [47:0]           evicted_dirty_total,
  output logic [29:0]           resident_dirty_bytes
);
  import salc_pkg::*;

  localparam int SETS = 1 << MAX_SET_BITS;
  localparam int SIW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WW = $clog2(MAX_WAYS + 1);
  localparam int SBW = $clog2(MAX_SET_BITS + 1);
  // one way entry: valid, dirty, rank, tag
  localparam int EW = ADDR_WIDTH + RW + 2;
  localparam int ROWW = EW * MAX_WAYS;
  localparam logic [RW-1:0] RANK_MAX = RW'(MAX_WAYS - 1);

  // configuration registers
  logic [2:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways_in_use;
  logic cfg_clr;

  // only a defined register index invalidates the lines
  assign cfg_clr = cfg_we && (cfg_index <= REG_WAYS);

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= 3'd0;
      block_bits <= 5'd4;
      ways_in_use <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_BITS: set_bits <= cfg_data[2:0];
        REG_BLOCK_BITS: block_bits <= cfg_data;
        REG_WAYS: ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamped configuration
  logic [SBW-1:0] s_eff;
  logic [4:0] b_eff;
  logic [WW-1:0] ways_eff;
  always_comb begin
    s_eff = (int'(set_bits) > MAX_SET_BITS) ? SBW'(MAX_SET_BITS) : SBW'(set_bits);
    b_eff = (block_bits > 5'(MAX_BLOCK_BITS)) ? 5'(MAX_BLOCK_BITS) : block_bits;
    if (ways_in_use == 4'd0) begin
      ways_eff = WW'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways_eff = WW'(MAX_WAYS);
    end else begin
      ways_eff = WW'(ways_in_use);
    end
  end

  // request capture and address split
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [SIW-1:0] set_q;
  logic store_q;
  logic [ADDR_WIDTH-1:0] shifted;
  logic [SIW-1:0] set_mask;
  always_comb begin
    shifted = address >> b_eff;
    set_mask = SIW'((1 << s_eff) - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q <= SIW'(shifted) & set_mask;
      tag_q <= shifted >> s_eff;
      store_q <= action;
    end
  end

  // clearing sweep counter
  logic [SIW-1:0] clr_idx;
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + SIW'(1);
    end
  end
  assign sts = '{cfg_clr: cfg_clr, clr_last: (clr_idx == SIW'(SETS - 1))};

  // set row memory
  logic ram_we;
  logic [SIW-1:0] ram_addr;
  logic [ROWW-1:0] ram_wdata;
  logic [ROWW-1:0] ram_rdata;
  logic [ROWW-1:0] row_new;

  always_comb begin
    ram_we = cmd.clr_step || cmd.finish;
    ram_addr = cmd.clr_step ? clr_idx : (cmd.capture ? (SIW'(shifted) & set_mask) : set_q);
    ram_wdata = cmd.clr_step ? '0 : row_new;
  end

  salc_ram #(.WIDTH(ROWW), .DEPTH(SETS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // way compare, victim choice and LRU update
  logic [MAX_WAYS-1:0] v_w, d_w, hit_w;
  logic [RW-1:0] r_w [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] t_w [MAX_WAYS];
  logic found_hit, found_empty;
  logic [RW-1:0] sel, empty_sel, lru_sel, old_rank;
  logic [1:0] oc;
  logic wb_dirty;
  always_comb begin
    found_hit = 1'b0;
    found_empty = 1'b0;
    sel = '0;
    empty_sel = '0;
    lru_sel = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      v_w[j] = ram_rdata[j*EW + EW - 1];
      d_w[j] = ram_rdata[j*EW + EW - 2];
      r_w[j] = ram_rdata[j*EW + ADDR_WIDTH +: RW];
      t_w[j] = ram_rdata[j*EW +: ADDR_WIDTH];
      hit_w[j] = (j < int'(ways_eff)) && v_w[j] && (t_w[j] == tag_q);
    end
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (hit_w[j]) begin
        found_hit = 1'b1;
        sel = RW'(j);
      end
      if ((j < int'(ways_eff)) && !v_w[j]) begin
        found_empty = 1'b1;
        empty_sel = RW'(j);
      end
    end
    for (int j = 1; j < MAX_WAYS; j++) begin
      if ((j < int'(ways_eff)) && (r_w[j] > r_w[lru_sel])) begin
        lru_sel = RW'(j);
      end
    end
    if (found_hit) begin
      oc = OUT_HIT;
    end else if (found_empty) begin
      oc = OUT_FILL;
      sel = empty_sel;
    end else begin
      oc = OUT_EVICT;
      sel = lru_sel;
    end
    old_rank = r_w[sel];
    wb_dirty = (oc == OUT_EVICT) && d_w[sel];
  end

  // updated row: selected way becomes most recent, newer ways (all valid ways on a fill) age by one
  logic [ROWW-1:0] row_upd;
  always_comb begin
    row_upd = ram_rdata;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (RW'(j) == sel) begin
        row_upd[j*EW + EW - 1] = 1'b1;
        row_upd[j*EW + ADDR_WIDTH +: RW] = '0;
        row_upd[j*EW +: ADDR_WIDTH] = tag_q;
        row_upd[j*EW + EW - 2] = (oc == OUT_HIT) ? (d_w[j] || store_q) : store_q;
      end else if ((j < int'(ways_eff)) && v_w[j] &&
                   ((oc == OUT_FILL) || (r_w[j] < old_rank)) && (r_w[j] < RANK_MAX)) begin
        row_upd[j*EW + ADDR_WIDTH +: RW] = r_w[j] + RW'(1);
      end
    end
  end

  // decide stage registers
  logic [1:0] oc_q;
  logic [RW-1:0] sel_q;
  logic wb_q, sel_dirty_q;
  logic [20:0] bsize;
  assign bsize = 21'(1) << b_eff;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      oc_q <= oc;
      sel_q <= sel;
      wb_q <= wb_dirty;
      sel_dirty_q <= (oc == OUT_HIT) && d_w[sel];
      row_new <= row_upd;
    end
  end

  // statistics and result
  logic [30:0] res_after;
  always_comb begin
    res_after = {1'b0, resident_dirty_bytes};
    if (wb_q) begin
      res_after = (res_after >= 31'(bsize)) ? res_after - 31'(bsize) : '0;
    end
    if (store_q && !sel_dirty_q) begin
      res_after = res_after + 31'(bsize);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit_count <= '0;
      miss_count <= '0;
      eviction_count <= '0;
      evicted_dirty_total <= '0;
      resident_dirty_bytes <= '0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        outcome <= oc_q;
        written_back_bytes <= wb_q ? bsize : '0;
        if (oc_q == OUT_HIT) begin
          if (hit_count != '1) hit_count <= hit_count + 32'd1;
        end else if (miss_count != '1) begin
          miss_count <= miss_count + 32'd1;
        end
        if (oc_q == OUT_EVICT && eviction_count != '1) begin
          eviction_count <= eviction_count + 32'd1;
        end
        if (wb_q) begin
          evicted_dirty_total <= (evicted_dirty_total > 48'hFFFF_FFFF_FFFF - 48'(bsize)) ?
                                 '1 : evicted_dirty_total + 48'(bsize);
        end
        resident_dirty_bytes <= res_after[29:0];
      end else if (cfg_clr) begin
        resident_dirty_bytes <= '0;
      end
    end
  end
endmodule

// ===== hw/rtl/set_assoc_lru_writeback_cache_tags_top.sv =====
// A request taken at a start edge passes row read, compare/update and row write
// before its result strobe, with busy high meanwhile. A defined register write
// while idle or clearing, and reset, run a clearing sweep of all 2^MAX_SET_BITS
// set rows (64 by default), one set row per cycle; busy stays high.
// Results are strobed by done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_tags_top
// Tag store of a set-associative write-back cache with true LRU replacement.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_tags_top #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_D,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_D,
  parameter int ADDR_WIDTH = salc_pkg::ADDR_WIDTH_D
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [4:0]            cfg_data,
  input  logic [ADDR_WIDTH-1:0] address,
  input  logic                  action,
  output logic                  done,
  output logic [1:0]            outcome,
  output logic [20:0]           written_back_bytes,
  output logic [31:0]           hit_count,
  output logic [31:0]           miss_count,
  output logic [31:0]           eviction_count,
  output logic [47:0]           evicted_dirty_total,
  output logic [29:0]           resident_dirty_bytes
);
  import salc_pkg::*;

  salc_cmd_t cmd;
  salc_sts_t sts;

  salc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  salc_dp #(
    .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .ADDR_WIDTH(ADDR_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .address(address), .action(action), .done(done), .outcome(outcome),
    .written_back_bytes(written_back_bytes), .hit_count(hit_count),
    .miss_count(miss_count), .eviction_count(eviction_count),
    .evicted_dirty_total(evicted_dirty_total),
    .resident_dirty_bytes(resident_dirty_bytes)
  );
endmodule

// ===== hw/rtl/salc_checker.sv =====
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks of the cache tag store, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module salc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  outcome,
  input logic [20:0] written_back_bytes,
  input logic [31:0] hit_count
);
  import salc_pkg::*;

  // an accepted request is followed by its result strobe
  `CHK_AT(a_latency, clk, rst, (start && !busy) |=> ##2 done)
  // busy is held high across reset
  `CHK_ALWAYS(a_reset_busy, clk, rst |=> busy)
  // no eviction means no write-back
  `CHK_AT(a_wb_evict, clk, rst, (done && outcome != OUT_EVICT) |-> written_back_bytes == 21'd0)
  // a hit moves the hit count
  `CHK_AT(a_hit_cnt, clk, rst,
          (done && outcome == OUT_HIT && $past(hit_count) != 32'hFFFF_FFFF) |->
          hit_count != $past(hit_count))
endmodule

bind set_assoc_lru_writeback_cache_tags_top salc_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .outcome(outcome), .written_back_bytes(written_back_bytes), .hit_count(hit_count)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU write-back tag store: a
// scoreboard predicts hit, fill or evict, write-back bytes and the running
// totals for every accepted request, across several cache geometries.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import salc_pkg::*;

  typedef struct {
    logic [1:0]  outcome;
    logic [20:0] wb_bytes;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
    logic [47:0] dirty_out;
    logic [29:0] dirty_held;
  } access_result_t;

  // scoreboard: own copy of the tag store, predicts each request's result
  class tag_store_board;
    bit          valid[512];
    logic [63:0] tag[512];
    bit          dirty[512];
    int unsigned rank[512];
    logic [63:0] hits, misses, evictions, dirty_out, dirty_held;
    logic [2:0]  set_bits;
    logic [4:0]  block_bits;
    logic [3:0]  ways_reg;
    access_result_t pending[$];
    int errors;

    function new();
      set_bits = 0; block_bits = 4; ways_reg = 1;
      hits = 0; misses = 0; evictions = 0; dirty_out = 0; dirty_held = 0;
      errors = 0;
      clear_lines();
    endfunction

    function void clear_lines();
      foreach (valid[i]) begin
        valid[i] = 0; dirty[i] = 0; rank[i] = 0; tag[i] = '0;
      end
      dirty_held = 0;
    endfunction

    function int eff_sets();
      return (set_bits > MAX_SET_BITS_D) ? MAX_SET_BITS_D : set_bits;
    endfunction

    function int eff_block();
      return (block_bits > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : block_bits;
    endfunction

    function int eff_ways();
      if (ways_reg == 0) return 1;
      return (ways_reg > MAX_WAYS_D) ? MAX_WAYS_D : ways_reg;
    endfunction

    function logic [63:0] sat(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
      return (a >= lim || b > lim - a) ? lim : a + b;
    endfunction

    function void write_reg(logic [1:0] idx, logic [4:0] val);
      case (idx)
        REG_SET_BITS: set_bits = val[2:0];
        REG_BLOCK_BITS: block_bits = val;
        REG_WAYS: ways_reg = val[3:0];
        default: return;
      endcase
      clear_lines();
    endfunction

    // make way w most recent, ways newer than its old rank age by one
    function void touch(int base, int ways, int w, int unsigned old_rank);
      for (int j = 0; j < ways; j++)
        if (j != w && valid[base+j] && rank[base+j] < old_rank && rank[base+j] < MAX_WAYS_D-1)
          rank[base+j]++;
      rank[base+w] = 0;
    endfunction

    function void note_access(logic [63:0] addr, logic is_store);
      int s, b, ways, base, w;
      logic [63:0] bsize, tg;
      bit found;
      access_result_t r;
      s = eff_sets(); b = eff_block(); ways = eff_ways();
      bsize = 64'd1 << b;
      base = int'((addr >> b) & ((64'd1 << s) - 1)) * MAX_WAYS_D;
      tg = addr >> (b + s);
      found = 0; w = 0;
      r.outcome = OUT_HIT; r.wb_bytes = '0;
      for (int j = 0; j < ways && !found; j++)
        if (valid[base+j] && tag[base+j] == tg) begin
          w = j; found = 1;
        end
      if (found) begin
        hits = sat(hits, 1, 64'hFFFF_FFFF);
        touch(base, ways, w, rank[base+w]);
      end else begin
        misses = sat(misses, 1, 64'hFFFF_FFFF);
        for (int j = 0; j < ways && !found; j++)
          if (!valid[base+j]) begin
            w = j; found = 1;
          end
        if (found) begin
          // fill the first empty way
          r.outcome = OUT_FILL;
          valid[base+w] = 1; tag[base+w] = tg; dirty[base+w] = 0;
          touch(base, ways, w, 255);
        end else begin
          // evict lowest way holding the oldest rank
          r.outcome = OUT_EVICT;
          evictions = sat(evictions, 1, 64'hFFFF_FFFF);
          w = 0;
          for (int j = 1; j < ways; j++)
            if (rank[base+j] > rank[base+w]) w = j;
          if (dirty[base+w]) begin
            r.wb_bytes = bsize[20:0];
            dirty_out = sat(dirty_out, bsize, 64'hFFFF_FFFF_FFFF);
            dirty_held = (dirty_held >= bsize) ? dirty_held - bsize : 0;
            dirty[base+w] = 0;
          end
          tag[base+w] = tg;
          touch(base, ways, w, rank[base+w]);
        end
      end
      if (is_store && !dirty[base+w]) begin
        dirty[base+w] = 1;
        dirty_held += bsize;
      end
      r.hits = hits[31:0]; r.misses = misses[31:0]; r.evictions = evictions[31:0];
      r.dirty_out = dirty_out[47:0]; r.dirty_held = dirty_held[29:0];
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(access_result_t got);
      access_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none actual outcome %0h", $time,
                 got.outcome);
        return;
      end
      e = pending.pop_front();
      cmp("outcome", e.outcome, got.outcome);
      cmp("written_back_bytes", e.wb_bytes, got.wb_bytes);
      cmp("hit_count", e.hits, got.hits);
      cmp("miss_count", e.misses, got.misses);
      cmp("eviction_count", e.evictions, got.evictions);
      cmp("evicted_dirty_total", e.dirty_out, got.dirty_out);
      cmp("resident_dirty_bytes", e.dirty_held, got.dirty_held);
    endfunction
  endclass

  logic        clk, rst, start, busy, cfg_we, action, done;
  logic [1:0]  cfg_index, outcome;
  logic [4:0]  cfg_data;
  logic [63:0] address;
  logic [20:0] written_back_bytes;
  logic [31:0] hit_count, miss_count, eviction_count;
  logic [47:0] evicted_dirty_total;
  logic [29:0] resident_dirty_bytes;

  tag_store_board board = new();
  int cycles = 0;
  bit quiet = 0;

  set_assoc_lru_writeback_cache_tags_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .address(address), .action(action), .done(done), .outcome(outcome),
    .written_back_bytes(written_back_bytes), .hit_count(hit_count),
    .miss_count(miss_count), .eviction_count(eviction_count),
    .evicted_dirty_total(evicted_dirty_total),
    .resident_dirty_bytes(resident_dirty_bytes)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result monitor and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done)
      board.check_result('{outcome, written_back_bytes, hit_count, miss_count,
                           eviction_count, evicted_dirty_total, resident_dirty_bytes});
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // issue one request, held until the block takes it
  task automatic send(logic [63:0] a, logic st);
    @(negedge clk);
    while (busy) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1; address <= a; action <= st;
    @(posedge clk);
    board.note_access(a, st);
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) begin
      @(negedge clk);
      start <= 0;
    end
  endtask

  // register write once all requests have drained
  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(negedge clk);
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // mostly addresses from a few tags per set so hits and evictions occur
  function automatic logic [63:0] pick_addr();
    int s, b;
    logic [63:0] tg, a;
    s = board.eff_sets(); b = board.eff_block();
    if ($urandom_range(0, 99) < 8) return {$urandom, $urandom};
    tg = $urandom_range(0, board.eff_ways() + 2);
    if ($urandom_range(0, 7) == 0) tg[63 - b - s] = 1;
    a = (tg << (b + s)) | ((64'($urandom) & ((64'd1 << s) - 1)) << b);
    return a | (64'($urandom) & ((64'd1 << b) - 1));
  endfunction

  initial begin
    logic [4:0] cfgs[7][3];
    cfgs = '{'{2, 4, 4}, '{6, 20, 8}, '{7, 31, 15}, '{0, 0, 0},
             '{3, 2, 2}, '{1, 5, 8}, '{5, 12, 3}};
    rst = 1; start = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    address = '0; action = 0;
    repeat (11) @(negedge clk);
    rst <= 0;

    // directed: one-way direct-mapped reset geometry
    send(64'h0, 0);                   // fill
    send(64'h0, 1);                   // hit, line goes dirty
    send(64'hF, 1);                   // store to dirty line
    send(64'h10, 0);                  // evict dirty line
    send('1, 0);                      // evict clean line
    send('1, 1);
    send(64'h0, 1);                   // evict dirty, all-ones address
    send(64'h8000_0000_0000_0000, 0);
    // unused register index: no effect
    write_reg(2'd3, 5'h1F);
    send(64'h0, 0);
    write_reg(REG_WAYS, 2);
    send(64'h00, 1); send(64'h10, 1); send(64'h00, 0);
    send(64'h20, 0);                  // evicts the least recent way
    send(64'h10, 0); send(64'h00, 0);

    // random phases over several geometries
    for (int p = 0; p < 7; p++) begin
      write_reg(REG_SET_BITS, cfgs[p][0]);
      write_reg(REG_BLOCK_BITS, cfgs[p][1]);
      write_reg(REG_WAYS, cfgs[p][2]);
      quiet = (p == 6);
      for (int i = 0; i < 215; i++) begin
        send(pick_addr(), $urandom_range(0, 1));
        if (!quiet && $urandom_range(0, 3) == 0) gap();
      end
    end

    @(negedge clk);
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
